>>> rtl/bsss_pkg.sv
// ----------------------------------------------------------------------------
// Box sort/suppress package
// Shared widths, register indexes and geometry record for the NMS block.
// ----------------------------------------------------------------------------
package bsss_pkg;

  localparam int MaxBoxes = 32;
  localparam int IdxW     = $clog2(MaxBoxes);
  localparam int CntW     = $clog2(MaxBoxes + 1);

  localparam logic [1:0] RegThresh = 2'd0;
  localparam logic [1:0] RegScaleX = 2'd1;
  localparam logic [1:0] RegScaleY = 2'd2;
  localparam logic [1:0] RegKeep   = 2'd3;

  typedef struct packed {
    logic signed [15:0] h;
    logic signed [15:0] w;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } geo_t;

  typedef struct packed {
    logic signed [15:0] score;
    geo_t               geo;
    logic [7:0]         cls;
  } box_t;

  function automatic logic signed [15:0] sat16(input logic signed [42:0] v);
    logic signed [15:0] r;
    if (v > 43'sd32767) r = 16'sh7fff;
    else if (v < -43'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  // Truncating arithmetic shift toward zero: add (2^s - 1) on negatives.
  function automatic logic signed [42:0] tdiv(input logic signed [42:0] p,
                                             input logic sel26);
    logic signed [42:0] r;
    if (sel26) r = (p + (p[42] ? 43'sd67108863 : 43'sd0)) >>> 26;
    else r = (p + (p[42] ? 43'sd1048575 : 43'sd0)) >>> 20;
    return r;
  endfunction

endpackage

>>> rtl/bsss_geo.sv
// ----------------------------------------------------------------------------
// Box geometry converter
// Two-stage conversion of raw Q20/Q26 values to pixel corner geometry.
// ----------------------------------------------------------------------------
module bsss_geo (
  input  logic                clk,
  input  logic signed [31:0]  cx_raw,
  input  logic signed [31:0]  cy_raw,
  input  logic signed [31:0]  w_raw,
  input  logic signed [31:0]  h_raw,
  input  logic [9:0]          sx,
  input  logic [9:0]          sy,
  output bsss_pkg::geo_t      geo
);
  logic signed [15:0] cx_r, cy_r, w_r, h_r;
  logic signed [42:0] pcx, pcy, pw, ph;
  logic signed [16:0] hx, hy;

  always_comb begin
    pcx = 43'(cx_raw * $signed({1'b0, sx}));
    pcy = 43'(cy_raw * $signed({1'b0, sy}));
    pw  = 43'(w_raw * $signed({1'b0, sx}));
    ph  = 43'(h_raw * $signed({1'b0, sy}));
  end

  // stage one: products scaled and saturated
  always_ff @(posedge clk) begin
    cx_r <= bsss_pkg::sat16(bsss_pkg::tdiv(pcx, 1'b0));
    cy_r <= bsss_pkg::sat16(bsss_pkg::tdiv(pcy, 1'b0));
    w_r  <= bsss_pkg::sat16(bsss_pkg::tdiv(pw, 1'b1));
    h_r  <= bsss_pkg::sat16(bsss_pkg::tdiv(ph, 1'b1));
  end

  // half size truncated toward zero
  always_comb begin
    hx = (17'(w_r) + (w_r[15] ? 17'sd1 : 17'sd0)) >>> 1;
    hy = (17'(h_r) + (h_r[15] ? 17'sd1 : 17'sd0)) >>> 1;
    geo.x = bsss_pkg::sat16(43'(17'(cx_r) - hx));
    geo.y = bsss_pkg::sat16(43'(17'(cy_r) - hy));
    geo.w = w_r;
    geo.h = h_r;
  end
endmodule

>>> rtl/box_sort_suppress_select_unit.sv
// ----------------------------------------------------------------------------
// Box sort, suppress and select unit
// Greedy non-maximum suppression on intersection area over one frame.
// ----------------------------------------------------------------------------
// channel | direction | handshake        | word
// in_     | in        | in_valid/stall   | one raw box, last ends the frame
// out_    | out       | out_valid/stall  | one sorted box with keep flag
// cfg_    | in        | cfg_valid/ready  | register index and data
//
// Loading: each box is accepted in S_IDLE, then written to the store in S_GEO; input stalls meanwhile.
// Frame end: bubble passes through the box memory, at most N passes, until a
// pass makes no swap; suppression then compares each live box with every other
// one and skips dropped ones; then the output words, held by any output stall.
// rst_n is synchronous; it clears control and the configuration registers, not the box memory.
// Output stall holds the output register; the sequencer waits on it.
module box_sort_suppress_select_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_score,
  input  logic signed [31:0] in_center_x_raw,
  input  logic signed [31:0] in_center_y_raw,
  input  logic signed [31:0] in_width_raw,
  input  logic signed [31:0] in_height_raw,
  input  logic [7:0]         in_class_id,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         out_rank,
  output logic signed [15:0] out_score,
  output logic signed [15:0] out_corner_x,
  output logic signed [15:0] out_corner_y,
  output logic signed [15:0] out_pixel_width,
  output logic signed [15:0] out_pixel_height,
  output logic [7:0]         out_out_class,
  output logic               out_kept,
  output logic               out_final_res,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data
);
  localparam int IW = bsss_pkg::IdxW;
  localparam int CW = bsss_pkg::CntW;

  localparam logic [3:0] S_IDLE = 4'd0, S_GEO = 4'd1, S_SRD0 = 4'd2,
    S_SLD = 4'd3, S_SCMP = 4'd4, S_SEND = 4'd5, S_NI = 4'd6,
    S_NIL = 4'd7, S_NJ = 4'd8, S_ORD = 4'd9, S_OUT = 4'd10;

  logic [30:0] thr_r;
  logic [9:0]  sx_r, sy_r;
  logic [6:0]  keep_r;

  logic [3:0]    st_r, st_nxt;
  logic [CW-1:0] cnt_r;
  logic          last_r;
  logic [IW-1:0] i_r, j_r;
  logic [6:0]    kc_r;
  logic          swapped_r, ovalid_r;
  logic [bsss_pkg::MaxBoxes-1:0] alive_r;
  bsss_pkg::box_t cur_r, a_r, rd_q;
  logic signed [15:0] sc_r;
  logic [7:0]  cl_r;
  bsss_pkg::geo_t geo;

  // box memory, registered read
  bsss_pkg::box_t mem [bsss_pkg::MaxBoxes];
  logic          we;
  logic [IW-1:0] wa, ra;
  bsss_pkg::box_t wd;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  bsss_geo u_geo (
    .clk(clk), .cx_raw(in_center_x_raw), .cy_raw(in_center_y_raw),
    .w_raw(in_width_raw), .h_raw(in_height_raw), .sx(sx_r), .sy(sy_r),
    .geo(geo)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (st_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 31'd1; sx_r <= 10'd160; sy_r <= 10'd128; keep_r <= 7'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bsss_pkg::RegThresh: thr_r <= cfg_data;
        bsss_pkg::RegScaleX: sx_r <= cfg_data[9:0];
        bsss_pkg::RegScaleY: sy_r <= cfg_data[9:0];
        bsss_pkg::RegKeep:   keep_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // overlap area of the held box a_r against the box just read
  logic signed [15:0] ox, oy;
  logic signed [16:0] ea, eb, fa, fb, ex, ey;
  logic signed [17:0] sxo, syo;
  logic [33:0] area;
  logic hit;
  always_comb begin
    ox = (a_r.geo.x > rd_q.geo.x) ? a_r.geo.x : rd_q.geo.x;
    oy = (a_r.geo.y > rd_q.geo.y) ? a_r.geo.y : rd_q.geo.y;
    ea = 17'(a_r.geo.x) + 17'(a_r.geo.w);
    eb = 17'(rd_q.geo.x) + 17'(rd_q.geo.w);
    fa = 17'(a_r.geo.y) + 17'(a_r.geo.h);
    fb = 17'(rd_q.geo.y) + 17'(rd_q.geo.h);
    ex = (ea < eb) ? ea : eb;
    ey = (fa < fb) ? fa : fb;
    // spans reach about 3 * 2^15, so keep 18 signed bits
    sxo = 18'(ex) - 18'(ox);
    syo = 18'(ey) - 18'(oy);
    area = '0;
    if (sxo > 18'sd0 && syo > 18'sd0)
      area = 34'(sxo[16:0]) * 34'(syo[16:0]);
    hit = area >= 34'(thr_r);
  end

  logic [IW-1:0] nmax, nm2;
  logic          i_last, j_last, swap, oload, keep_hit;
  assign nmax     = IW'(cnt_r - 1'b1);
  assign nm2      = IW'(cnt_r - CW'(2));
  assign i_last   = (i_r == nmax);
  assign j_last   = (j_r == nmax);
  // bubble step: drop the lower score to the right, ties stay in order
  assign swap     = cur_r.score < rd_q.score;
  assign oload    = (st_r == S_OUT) && (!ovalid_r || !out_stall);
  assign keep_hit = alive_r[i_r] && (kc_r < keep_r);

  always_comb begin
    we = 1'b0; wa = i_r; wd = cur_r; ra = i_r;
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (in_valid) st_nxt = S_GEO;
      S_GEO: begin
        // store the box unless the memory is full
        if (cnt_r < CW'(bsss_pkg::MaxBoxes)) begin
          we = 1'b1; wa = IW'(cnt_r);
          wd = '{score: sc_r, geo: geo, cls: cl_r};
        end
        if (!last_r) st_nxt = S_IDLE;
        else if (cnt_r != '0) st_nxt = S_SRD0;
        else st_nxt = S_NI;
      end
      S_SRD0: begin ra = '0; st_nxt = S_SLD; end
      S_SLD: begin ra = IW'(1); st_nxt = S_SCMP; end
      S_SCMP: begin
        we = 1'b1; wa = i_r; wd = swap ? rd_q : cur_r;
        ra = i_r + IW'(2);
        st_nxt = (i_r == nm2) ? S_SEND : S_SCMP;
      end
      S_SEND: begin
        we = 1'b1; wa = nmax; wd = cur_r;
        st_nxt = swapped_r ? S_SRD0 : S_NI;
      end
      S_NI: st_nxt = S_NIL;
      S_NIL: begin
        ra = '0;
        if (alive_r[i_r]) st_nxt = S_NJ;
        else st_nxt = i_last ? S_ORD : S_NI;
      end
      S_NJ: begin
        ra = j_r + IW'(1);
        if (j_last) st_nxt = i_last ? S_ORD : S_NI;
      end
      S_ORD: st_nxt = S_OUT;
      S_OUT: if (oload) st_nxt = i_last ? S_IDLE : S_ORD;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= '0; i_r <= '0; j_r <= '0; kc_r <= '0;
      swapped_r <= 1'b0; ovalid_r <= 1'b0; last_r <= 1'b0; alive_r <= '0;
    end else begin
      st_r <= st_nxt;
      unique case (st_r)
        S_IDLE: if (in_valid) begin
          sc_r <= in_score; cl_r <= in_class_id; last_r <= in_last;
        end
        S_GEO: begin
          if (cnt_r < CW'(bsss_pkg::MaxBoxes)) cnt_r <= cnt_r + 1'b1;
          i_r <= '0; swapped_r <= 1'b0; alive_r <= '1;
        end
        S_SLD: cur_r <= rd_q;
        S_SCMP: begin
          if (swap) swapped_r <= 1'b1;
          else cur_r <= rd_q;
          if (i_r != nm2) i_r <= i_r + 1'b1;
        end
        S_SEND: begin i_r <= '0; swapped_r <= 1'b0; end
        S_NIL: begin
          a_r <= rd_q; j_r <= '0;
          // skip a box that is already suppressed
          if (!alive_r[i_r]) i_r <= i_last ? '0 : i_r + 1'b1;
        end
        S_NJ: begin
          if (j_r != i_r && alive_r[j_r] && hit) alive_r[j_r] <= 1'b0;
          if (j_last) begin
            j_r <= '0;
            i_r <= i_last ? '0 : i_r + 1'b1;
          end else j_r <= j_r + 1'b1;
        end
        S_OUT: if (oload) begin
          out_rank <= 6'(i_r);
          out_score <= rd_q.score;
          out_corner_x <= rd_q.geo.x;
          out_corner_y <= rd_q.geo.y;
          out_pixel_width <= rd_q.geo.w;
          out_pixel_height <= rd_q.geo.h;
          out_out_class <= rd_q.cls;
          out_kept <= keep_hit;
          out_final_res <= i_last;
          if (i_last) begin
            cnt_r <= '0; kc_r <= '0; i_r <= '0;
          end else begin
            i_r <= i_r + 1'b1;
            if (keep_hit) kc_r <= kc_r + 1'b1;
          end
        end
        default: ;
      endcase
      if (oload) ovalid_r <= 1'b1;
      else if (!out_stall) ovalid_r <= 1'b0;
    end
  end

  assign out_valid = ovalid_r;
endmodule

>>> rtl/bsss_checker.sv
// ----------------------------------------------------------------------------
// Box sort/suppress port checker
// Watches the port behaviour of the top level over time.
// ----------------------------------------------------------------------------
module bsss_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input logic out_final_res,
  input logic [5:0] out_rank
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rank) && $stable(out_final_res))
    else $error("stalled result changed");
  a_rank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_final_res ##1 out_valid
    |-> out_rank != 6'd0)
    else $error("rank restarted inside a frame");
  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_final_res |=> !out_valid || out_rank == 6'd0)
    else $error("new frame did not start at rank zero");
endmodule

bind box_sort_suppress_select_unit bsss_checker u_bsss_checker (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_final_res(out_final_res), .out_rank(out_rank)
);

>>> tb/box_sort_suppress_select_unit_tb.sv
// ----------------------------------------------------------------------------
// Box sort/suppress/select unit testbench
// Loads frames of detection boxes and builds its own sorted, suppressed and
// count-limited result list per frame. It checks every output word field by
// field, with random idling and stalls on both channels.
// ----------------------------------------------------------------------------
module box_sort_suppress_select_unit_tb;

  localparam int  StoreDepth = 32;
  localparam int  DrainWait  = 40;
  localparam longint CycleLimit = 2000000;

  typedef struct {
    logic signed [15:0] score;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] w;
    logic signed [31:0] h;
    logic [7:0]         cls;
    logic               last;
  } raw_box_t;

  typedef struct {
    logic signed [15:0] score;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] w;
    logic signed [15:0] h;
    logic [7:0]         cls;
  } pix_box_t;

  typedef struct {
    logic [5:0]         rank;
    logic signed [15:0] score;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] w;
    logic signed [15:0] h;
    logic [7:0]         cls;
    logic               kept;
    logic               final_res;
  } sorted_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_score = '0;
  logic signed [31:0] in_center_x_raw = '0;
  logic signed [31:0] in_center_y_raw = '0;
  logic signed [31:0] in_width_raw = '0;
  logic signed [31:0] in_height_raw = '0;
  logic [7:0]         in_class_id = '0;
  logic               in_last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [5:0]         out_rank;
  logic signed [15:0] out_score;
  logic signed [15:0] out_corner_x;
  logic signed [15:0] out_corner_y;
  logic signed [15:0] out_pixel_width;
  logic signed [15:0] out_pixel_height;
  logic [7:0]         out_out_class;
  logic               out_kept;
  logic               out_final_res;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [30:0]        cfg_data = '0;

  // register copies, as after reset
  logic [30:0] thresh_q = 31'd1;
  logic [9:0]  scale_x_q = 10'd160;
  logic [9:0]  scale_y_q = 10'd128;
  logic [6:0]  keep_q = 7'd1;

  raw_box_t     pending_boxes[$];
  pix_box_t     frame_boxes[$];
  sorted_word_t expected_words[$];

  bit     calm = 1'b0;
  bit     failed = 1'b0;
  longint cycles = 0;
  int     boxes_sent = 0;
  int     frames_done = 0;
  int     words_checked = 0;

  box_sort_suppress_select_unit u_dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic signed [15:0] clip16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Scale to pixels at the register values in force on arrival.
  function automatic pix_box_t to_pixels(input raw_box_t b);
    pix_box_t p;
    longint sx, sy, cxp, cyp;
    sx = longint'(scale_x_q);
    sy = longint'(scale_y_q);
    cxp = clip16(longint'(b.cx) * sx / 64'sd1048576);
    cyp = clip16(longint'(b.cy) * sy / 64'sd1048576);
    p.w = clip16(longint'(b.w) * sx / 64'sd67108864);
    p.h = clip16(longint'(b.h) * sy / 64'sd67108864);
    p.x = clip16(cxp - longint'(p.w) / 2);
    p.y = clip16(cyp - longint'(p.h) / 2);
    p.score = b.score;
    p.cls = b.cls;
    return p;
  endfunction

  function automatic longint shared_area(input pix_box_t a, input pix_box_t b);
    longint lx, ly, rx, ry;
    lx = (a.x > b.x) ? a.x : b.x;
    ly = (a.y > b.y) ? a.y : b.y;
    rx = (longint'(a.x) + a.w < longint'(b.x) + b.w) ? longint'(a.x) + a.w
                                                     : longint'(b.x) + b.w;
    ry = (longint'(a.y) + a.h < longint'(b.y) + b.h) ? longint'(a.y) + a.h
                                                     : longint'(b.y) + b.h;
    if (rx - lx <= 0 || ry - ly <= 0) return 0;
    return (rx - lx) * (ry - ly);
  endfunction

  // Sort, suppress, limit the survivors and queue the frame's words.
  task automatic close_frame();
    pix_box_t     ranked[$];
    bit           alive[$];
    sorted_word_t wd;
    int           pos, kept_n;
    foreach (frame_boxes[k]) begin
      // stable: insert after every box of equal or higher score
      pos = 0;
      while (pos < ranked.size() && ranked[pos].score >= frame_boxes[k].score) pos++;
      ranked.insert(pos, frame_boxes[k]);
      alive.push_back(1'b1);
    end
    for (int i = 0; i < ranked.size(); i++) begin
      if (!alive[i]) continue;
      for (int j = 0; j < ranked.size(); j++) begin
        if (j == i || !alive[j]) continue;
        if (shared_area(ranked[i], ranked[j]) >= longint'(thresh_q)) alive[j] = 1'b0;
      end
    end
    kept_n = 0;
    for (int i = 0; i < ranked.size(); i++) begin
      if (alive[i]) begin
        if (kept_n < keep_q) kept_n++;
        else alive[i] = 1'b0;
      end
      wd.rank = i[5:0];
      wd.score = ranked[i].score;
      wd.x = ranked[i].x;
      wd.y = ranked[i].y;
      wd.w = ranked[i].w;
      wd.h = ranked[i].h;
      wd.cls = ranked[i].cls;
      wd.kept = alive[i];
      wd.final_res = (i == ranked.size() - 1);
      expected_words.push_back(wd);
    end
    frame_boxes.delete();
    frames_done++;
  endtask

  // Driver: predict on each accepted word, then present the next one.
  always @(posedge clk) begin
    raw_box_t b;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        b.score = in_score;
        b.cx = in_center_x_raw;
        b.cy = in_center_y_raw;
        b.w = in_width_raw;
        b.h = in_height_raw;
        b.cls = in_class_id;
        b.last = in_last;
        // drop a box that arrives with the store full
        if (frame_boxes.size() < StoreDepth) frame_boxes.push_back(to_pixels(b));
        if (b.last) close_frame();
      end
      if (pending_boxes.size() > 0 && (calm || $urandom_range(0, 99) >= 31)) begin
        b = pending_boxes.pop_front();
        in_valid <= 1'b1;
        in_score <= b.score;
        in_center_x_raw <= b.cx;
        in_center_y_raw <= b.cy;
        in_width_raw <= b.w;
        in_height_raw <= b.h;
        in_class_id <= b.cls;
        in_last <= b.last;
        boxes_sent++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      failed = 1'b1;
    end
  endtask

  // Monitor: compare each accepted output word with the oldest expectation.
  always @(posedge clk) begin
    sorted_word_t wd;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("output word with nothing expected (rank %0d)", out_rank);
          failed = 1'b1;
        end else begin
          wd = expected_words.pop_front();
          check_field("rank", wd.rank, out_rank);
          check_field("out_score", wd.score, out_score);
          check_field("corner_x", wd.x, out_corner_x);
          check_field("corner_y", wd.y, out_corner_y);
          check_field("pixel_width", wd.w, out_pixel_width);
          check_field("pixel_height", wd.h, out_pixel_height);
          check_field("out_class", wd.cls, out_out_class);
          check_field("kept", wd.kept, out_kept);
          check_field("final_res", wd.final_res, out_final_res);
          words_checked++;
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 31);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("box_sort_suppress_select_unit: mismatch");
      $finish;
    end
  end

  // Hold until both channels are quiet, then let the block settle.
  task automatic wait_drained();
    while (pending_boxes.size() > 0 || in_valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  // One register write; cfg_valid then drops before the task returns.
  task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      bsss_pkg::RegThresh: thresh_q = val;
      bsss_pkg::RegScaleX: scale_x_q = val[9:0];
      bsss_pkg::RegScaleY: scale_y_q = val[9:0];
      bsss_pkg::RegKeep:   keep_q = val[6:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [30:0] thr, input logic [9:0] sx,
                          input logic [9:0] sy, input logic [6:0] keep);
    write_reg(bsss_pkg::RegThresh, thr);
    write_reg(bsss_pkg::RegScaleX, {21'd0, sx});
    write_reg(bsss_pkg::RegScaleY, {21'd0, sy});
    write_reg(bsss_pkg::RegKeep, {24'd0, keep});
  endtask

  task automatic add_box(input logic signed [15:0] sc, input logic signed [31:0] cx,
                         input logic signed [31:0] cy, input logic signed [31:0] w,
                         input logic signed [31:0] h, input logic [7:0] cls,
                         input logic last);
    raw_box_t b;
    b.score = sc; b.cx = cx; b.cy = cy; b.w = w; b.h = h; b.cls = cls; b.last = last;
    pending_boxes.push_back(b);
  endtask

  // Mostly in-frame boxes so overlaps are common; sometimes raw noise.
  task automatic add_random_box(input logic last);
    logic signed [15:0] sc;
    if ($urandom_range(0, 3) == 0) sc = 16'($urandom_range(0, 3));
    else sc = 16'($urandom);
    if ($urandom_range(0, 4) == 0)
      add_box(sc, $urandom, $urandom, $urandom, $urandom, 8'($urandom), last);
    else
      add_box(sc, $urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20),
              $urandom_range(0, 1 << 25), $urandom_range(0, 1 << 25), 8'($urandom),
              last);
  endtask

  task automatic add_random_frame(input int n);
    for (int k = 0; k < n; k++) add_random_box(k == n - 1);
  endtask

  initial begin
    int sent_goal;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, equal scores, negative sizes, reset registers.
    add_box(16'sh7fff, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
            8'd0, 1'b0);
    add_box(16'sh8000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
            8'd255, 1'b0);
    add_box(16'sd5, 32'sh00080000, 32'sh00080000, 32'sh01000000, 32'sh01000000, 8'd1, 1'b0);
    add_box(16'sd5, 32'sh00081000, 32'sh00080000, 32'sh01000000, 32'sh01000000, 8'd2, 1'b0);
    add_box(16'sd0, -32'sd1, -32'sd1, -32'sd1, -32'sd1, 8'd3, 1'b1);
    // single-box frame
    add_box(16'sd100, 32'sh00040000, 32'sh00040000, 32'sh00800000, 32'sh00800000,
            8'd7, 1'b1);
    wait_drained();

    // Threshold zero suppresses everything but the top box; keep above count.
    set_regs(31'd0, 10'd1023, 10'd1023, 7'd64);
    add_random_frame(6);
    wait_drained();

    // Largest threshold, zero scale, nothing kept.
    set_regs(31'h7fffffff, 10'd0, 10'd0, 7'd0);
    add_random_frame(5);
    wait_drained();

    // Overfilled store, last on a dropped box.
    set_regs(31'd40, 10'd160, 10'd128, 7'd5);
    for (int k = 0; k < StoreDepth + 3; k++) add_random_box(k == StoreDepth + 2);
    wait_drained();

    // Scale change between boxes of one frame.
    add_random_box(1'b0);
    add_random_box(1'b0);
    wait_drained();
    write_reg(bsss_pkg::RegScaleX, 31'd1);
    write_reg(bsss_pkg::RegScaleY, 31'd1023);
    add_random_box(1'b0);
    add_random_box(1'b1);
    wait_drained();

    // Random phases, each under its own register setting.
    sent_goal = boxes_sent + 360;
    for (int ph = 0; boxes_sent < sent_goal; ph++) begin
      set_regs($urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 600)),
               10'($urandom_range(1, 1023)), 10'($urandom_range(1, 1023)),
               7'($urandom_range(0, 64)));
      calm = (ph == 3);
      for (int f = 0; f < 6; f++)
        add_random_frame(($urandom_range(0, 9) == 0) ? $urandom_range(20, 34)
                                                     : $urandom_range(1, 10));
      wait_drained();
    end
    calm = 1'b0;

    $display("Checked %0d output words over %0d frames from %0d boxes,", words_checked,
             frames_done, boxes_sent);
    $display("with threshold, scale and keep limits swept across their extremes.");
    if (!failed && expected_words.size() == 0) begin
      $display("box_sort_suppress_select_unit: match");
    end else begin
      $display("box_sort_suppress_select_unit: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/bsss_pkg.sv
rtl/bsss_geo.sv
rtl/box_sort_suppress_select_unit.sv
rtl/bsss_checker.sv
tb/box_sort_suppress_select_unit_tb.sv
